// ===== rtl/core/r16x_pkg.sv =====
// Shared opcodes, status codes, defaults and controller/datapath interface types.
`default_nettype none
package r16x_pkg;
    localparam int unsigned REG_COUNT_DEF = 16;
    localparam int unsigned PC_INDEX_DEF  = 15;
    localparam int unsigned MEM_WORDS_DEF = 4096;

    localparam logic [4:0] OP_HALT  = 5'd0;
    localparam logic [4:0] OP_RET   = 5'd1;
    localparam logic [4:0] OP_CALLI = 5'd2;
    localparam logic [4:0] OP_DUMP  = 5'd3;
    localparam logic [4:0] OP_MOV8  = 5'd4;
    localparam logic [4:0] OP_MOV16 = 5'd5;
    localparam logic [4:0] OP_CALLR = 5'd6;
    localparam logic [4:0] OP_TRAP  = 5'd7;
    localparam logic [4:0] OP_LOAD  = 5'd8;
    localparam logic [4:0] OP_STORE = 5'd9;
    localparam logic [4:0] OP_ADD   = 5'd10;
    localparam logic [4:0] OP_SUB   = 5'd11;
    localparam logic [4:0] OP_MUL   = 5'd12;
    localparam logic [4:0] OP_DIV   = 5'd13;
    localparam logic [4:0] OP_MOD   = 5'd14;
    localparam logic [4:0] OP_OR    = 5'd15;
    localparam logic [4:0] OP_XOR   = 5'd16;
    localparam logic [4:0] OP_AND   = 5'd17;
    localparam logic [4:0] OP_NAND  = 5'd18;
    localparam logic [4:0] OP_BEQ   = 5'd19;
    localparam logic [4:0] OP_BGT   = 5'd20;
    localparam logic [4:0] OP_BLT   = 5'd21;
    localparam logic [4:0] OP_BNE   = 5'd22;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_HALT    = 4'd1;
    localparam logic [3:0] ST_DIVZ    = 4'd2;
    localparam logic [3:0] ST_MODZ    = 4'd3;
    localparam logic [3:0] ST_UNKNOWN = 4'd4;
    localparam logic [3:0] ST_MEMF    = 4'd5;
    localparam logic [3:0] ST_TRAP    = 4'd6;
    localparam logic [3:0] ST_CALL    = 4'd7;
    localparam logic [3:0] ST_RET     = 4'd8;
    localparam logic [3:0] ST_UTRAP   = 4'd9;

    typedef struct packed {
        logic capture;   // latch item, read operands
        logic div_start; // load divider
        logic div_step;  // one quotient bit
        logic mem_rd;    // issue memory read
        logic commit;    // write back and present result
    } dp_cmd_t;

    typedef struct packed {
        logic is_div;    // div or mod with nonzero divisor
        logic is_load;   // in-range load
        logic div_last;  // final divider step
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/r16x_ctrl.sv =====
// Controller state machine sequencing capture, divide, load and commit.
`default_nettype none
module r16x_ctrl
    import r16x_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);
    typedef enum logic [2:0] {S_IDLE, S_DEC, S_DIV, S_MEM, S_WB} state_t;
    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (start) state_reg <= S_DEC;
                S_DEC:
                begin
                    priority if (stat.is_div) state_reg <= S_DIV;
                    else if (stat.is_load)    state_reg <= S_MEM;
                    else                      state_reg <= S_WB;
                end
                S_DIV:  if (stat.div_last) state_reg <= S_WB;
                S_MEM:  state_reg <= S_WB;
                S_WB:   state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        cmd.capture   = (state_reg == S_IDLE) && start;
        cmd.div_start = (state_reg == S_DEC) && stat.is_div;
        cmd.div_step  = (state_reg == S_DIV);
        cmd.mem_rd    = (state_reg == S_DEC) && stat.is_load;
        cmd.commit    = (state_reg == S_WB);
    end
endmodule
`default_nettype wire

// ===== rtl/core/r16x_datapath.sv =====
// Datapath: register file, data memory, ALU, restoring divider, result registers.
`default_nettype none
module r16x_datapath
    import r16x_pkg::*;
#(
    parameter int unsigned REG_COUNT = REG_COUNT_DEF,
    parameter int unsigned PC_INDEX  = PC_INDEX_DEF,
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    input  wire logic        trap_en,
    input  wire logic [4:0]  mode,
    input  wire logic [3:0]  left_index,
    input  wire logic [3:0]  right_index,
    input  wire logic [15:0] immediate,
    output logic             done,
    output logic [3:0]       status,
    output logic             stopped,
    output logic             branch_taken,
    output logic [15:0]      target,
    output logic [15:0]      written_value
);
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MW = $clog2(MEM_WORDS);
    localparam logic [RW-1:0] PC_SEL = RW'(PC_INDEX % REG_COUNT);

    // index wraps at REG_COUNT (REG_COUNT >= 2); the 4-bit input is reduced by repeated compare-subtract
    function automatic logic [RW-1:0] reg_sel(input logic [3:0] idx);
        logic [6:0] v;
        v = {3'd0, idx};
        for (int k = 0; k < 8; k++)
        begin
            if (32'(v) >= REG_COUNT)
            begin
                v = v - 7'(REG_COUNT);
            end
        end
        return RW'(v);
    endfunction

    logic [15:0] rf_reg [REG_COUNT];
    logic [15:0] mem [MEM_WORDS];
    logic [15:0] mem_q;

    logic [4:0]    op_reg;
    logic [RW-1:0] li_reg;
    logic [15:0]   imm_reg, a_reg, b_reg;
    logic          stop_reg;
    logic [15:0]   quo_reg, rem_reg;
    logic [3:0]    cnt_reg;

    logic [RW-1:0] li_sel, ri_sel;
    assign li_sel = reg_sel(left_index);
    assign ri_sel = reg_sel(right_index);

    logic addr_ok;
    assign addr_ok = (32'(b_reg) < MEM_WORDS);

    assign stat.is_div   = !stop_reg && (op_reg == OP_DIV || op_reg == OP_MOD)
                           && (b_reg != 16'd0);
    assign stat.is_load  = !stop_reg && (op_reg == OP_LOAD) && addr_ok;
    assign stat.div_last = (cnt_reg == 4'd0);

    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    assign rem_sh  = {rem_reg, quo_reg[15]};
    assign rem_sub = rem_sh - {1'b0, b_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= mode;
            li_reg  <= li_sel;
            imm_reg <= immediate;
            a_reg   <= rf_reg[li_sel];
            b_reg   <= rf_reg[ri_sel];
        end
        if (cmd.div_start)
        begin
            quo_reg <= a_reg;
            rem_reg <= 16'd0;
            cnt_reg <= 4'd15;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[16])
            begin
                rem_reg <= rem_sub[15:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[15:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 4'd1;
        end
        if (cmd.mem_rd)
        begin
            mem_q <= mem[b_reg[MW-1:0]];
        end
        if (cmd.commit && !stop_reg && op_reg == OP_STORE && addr_ok)
        begin
            mem[b_reg[MW-1:0]] <= a_reg;
        end
    end

    logic [3:0]  st_c;
    logic        wr_c, tk_c;
    logic [15:0] res_c, tgt_c;
    logic [31:0] prod;
    assign prod = 32'(a_reg) * 32'(b_reg);

    always_comb
    begin
        st_c  = ST_OK;
        wr_c  = 1'b0;
        tk_c  = 1'b0;
        res_c = a_reg;
        tgt_c = 16'd0;
        unique case (op_reg)
            OP_HALT:  st_c = ST_HALT;
            OP_RET:   st_c = ST_RET;
            OP_CALLI: begin st_c = ST_CALL; tgt_c = imm_reg; end
            OP_DUMP:  ;
            OP_MOV8, OP_MOV16: begin res_c = imm_reg; wr_c = 1'b1; end
            OP_CALLR: begin st_c = ST_CALL; tgt_c = a_reg; end
            OP_TRAP:  st_c = trap_en ? ST_TRAP : ST_UTRAP;
            OP_LOAD:  if (addr_ok) begin res_c = mem_q; wr_c = 1'b1; end
                      else st_c = ST_MEMF;
            OP_STORE: if (!addr_ok) st_c = ST_MEMF;
            OP_ADD:   begin res_c = a_reg + b_reg; wr_c = 1'b1; end
            OP_SUB:   begin res_c = a_reg - b_reg; wr_c = 1'b1; end
            OP_MUL:   begin res_c = prod[15:0]; wr_c = 1'b1; end
            OP_DIV:   if (b_reg == 16'd0) st_c = ST_DIVZ;
                      else begin res_c = quo_reg; wr_c = 1'b1; end
            OP_MOD:   if (b_reg == 16'd0) st_c = ST_MODZ;
                      else begin res_c = rem_reg; wr_c = 1'b1; end
            OP_OR:    begin res_c = a_reg | b_reg; wr_c = 1'b1; end
            OP_XOR:   begin res_c = a_reg ^ b_reg; wr_c = 1'b1; end
            OP_AND:   begin res_c = a_reg & b_reg; wr_c = 1'b1; end
            OP_NAND:  begin res_c = ~(a_reg & b_reg); wr_c = 1'b1; end
            OP_BEQ:   tk_c = (a_reg == b_reg);
            OP_BGT:   tk_c = (a_reg > b_reg);
            OP_BLT:   tk_c = (a_reg < b_reg);
            OP_BNE:   tk_c = (a_reg != b_reg);
            default:  st_c = ST_UNKNOWN;
        endcase
        if (tk_c)
        begin
            tgt_c = imm_reg;
        end
    end

    logic fault_c;
    assign fault_c = (st_c == ST_HALT) || (st_c == ST_DIVZ) || (st_c == ST_MODZ) ||
                     (st_c == ST_UNKNOWN) || (st_c == ST_MEMF) || (st_c == ST_UTRAP);

    logic [15:0] wv_c;
    always_comb
    begin
        wv_c = wr_c ? res_c : a_reg;
        if (tk_c && li_reg == PC_SEL)
        begin
            wv_c = imm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= 16'd0;
            end
            stop_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= cmd.commit;
            if (cmd.commit && !stop_reg)
            begin
                if (wr_c)
                begin
                    rf_reg[li_reg] <= res_c;
                end
                if (tk_c)
                begin
                    rf_reg[PC_SEL] <= imm_reg;
                end
                if (fault_c)
                begin
                    stop_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (stop_reg)
            begin
                status        <= ST_OK;
                stopped       <= 1'b1;
                branch_taken  <= 1'b0;
                target        <= 16'd0;
                written_value <= a_reg;
            end
            else
            begin
                status        <= st_c;
                stopped       <= fault_c;
                branch_taken  <= tk_c;
                target        <= tgt_c;
                written_value <= wv_c;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/risc16_execute_unit.sv =====
// Each item runs capture, decode, the divider for div/mod with a nonzero divisor (16-step
// restoring divider) or a memory read for in-range loads, then writeback; done is registered.
// busy stays high until done rises, so a new item is taken only after the last one is done.
// Reset clears registers and the stop flag; data memory is undefined until written.
// Results appear for one cycle on done; the receiver cannot stall.
`default_nettype none
module risc16_execute_unit
    import r16x_pkg::*;
#(
    parameter int unsigned REG_COUNT = REG_COUNT_DEF,
    parameter int unsigned PC_INDEX  = PC_INDEX_DEF,
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  mode,
    input  wire logic [3:0]  left_index,
    input  wire logic [3:0]  right_index,
    input  wire logic [15:0] immediate,
    output logic             done,
    output logic [3:0]       status,
    output logic             stopped,
    output logic             branch_taken,
    output logic [15:0]      target,
    output logic [15:0]      written_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    logic     trap_en_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trap_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            trap_en_reg <= cfg_data;
        end
    end

    r16x_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    r16x_datapath #(
        .REG_COUNT (REG_COUNT),
        .PC_INDEX  (PC_INDEX),
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .trap_en       (trap_en_reg),
        .mode          (mode),
        .left_index    (left_index),
        .right_index   (right_index),
        .immediate     (immediate),
        .done          (done),
        .status        (status),
        .stopped       (stopped),
        .branch_taken  (branch_taken),
        .target        (target),
        .written_value (written_value)
    );
endmodule
`default_nettype wire
